// ----- sv/tcrp_pkg.sv -----
package tcrp_pkg;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_PROBE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_ESC     = 3'd0,
        PH_BRACKET = 3'd1,
        PH_FIRST   = 3'd2,
        PH_PARAMS  = 3'd3,
        PH_FINAL   = 3'd4,
        PH_DONE    = 3'd5,
        PH_BAD     = 3'd6
    } phase_t;

    localparam logic [1:0] ANS_UNKNOWN = 2'd0;
    localparam logic [1:0] ANS_PRESENT = 2'd1;
    localparam logic [1:0] ANS_ABSENT  = 2'd2;

    localparam logic [1:0] OVR_FORCE_ON  = 2'd1;
    localparam logic [1:0] OVR_FORCE_OFF = 2'd2;

    localparam logic [1:0] CFG_WINDOW     = 2'd0;
    localparam logic [1:0] CFG_OVR_SYNC   = 2'd1;
    localparam logic [1:0] CFG_OVR_KBD    = 2'd2;
    localparam logic [1:0] CFG_OVR_CLIP   = 2'd3;

    localparam int PARAM_W     = 24;
    localparam int WINDOW_W    = 16;
    localparam logic [PARAM_W-1:0] DIGIT_LIMIT = 24'd1000000;
    localparam logic [PARAM_W-1:0] PARAM_EXT52 = 24'd52;
    localparam logic [PARAM_W-1:0] PARAM_SYNC  = 24'd2026;

    localparam logic [7:0] CH_ESC     = 8'h1b;
    localparam logic [7:0] CH_BRACKET = 8'h5b;
    localparam logic [7:0] CH_QMARK   = 8'h3f;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_LOW_C   = 8'h63;
    localparam logic [7:0] CH_LOW_Y   = 8'h79;
    localparam logic [7:0] CH_LOW_U   = 8'h75;

    typedef struct packed {
        logic clip;
        logic clip_present;
        logic sync;
        logic sync_present;
        logic kbd;
    } reply_t;

    typedef struct packed {
        logic [1:0] sync_state;
        logic [1:0] keyboard_state;
        logic [1:0] clipboard_state;
        logic       sync_usable;
        logic       keyboard_usable;
        logic       clipboard_usable;
        logic       probe_running;
    } result_t;

endpackage

// ----- sv/terminal_capability_reply_parser.sv -----
// A word accepted at the input port is held in the input register, goes through the
// combinational parse and answer logic and is captured in the result register.
// Throughput: one word per cycle without result stall; a stall holds both registers.
// Reset: rst_n is asynchronous and active low; it clears the parser, the answers, the
// tick count and the probe, and loads the default configuration (window of 100 ticks).
module terminal_capability_reply_parser
    import tcrp_pkg::*;
#(
    parameter int TICK_WIDTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [1:0]          operation,
    input  logic [7:0]          reply_byte,
    input  logic                reply_last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [WINDOW_W-1:0] cfg_data,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [1:0]          sync_state,
    output logic [1:0]          keyboard_state,
    output logic [1:0]          clipboard_state,
    output logic                sync_usable,
    output logic                keyboard_usable,
    output logic                clipboard_usable,
    output logic                probe_running
);

    logic       in_valid_reg;
    op_t        op_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       res_valid_reg;
    result_t    res_reg;
    result_t    res_next;
    reply_t     reply;

    logic       advance;
    logic       step;
    logic       byte_step;

    assign advance    = !res_valid_reg || !result_stall;
    assign item_stall = in_valid_reg && !advance;
    assign step       = in_valid_reg && advance;
    assign byte_step  = step && (op_reg == OP_BYTE);
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            op_reg   <= op_t'(operation);
            byte_reg <= reply_byte;
            last_reg <= reply_last;
        end
    end

    tcrp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (byte_step),
        .reply_byte (byte_reg),
        .reply_last (last_reg),
        .reply      (reply)
    );

    tcrp_answers #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_answers (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .operation   (op_reg),
        .reply       (reply),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .result_next (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid     = res_valid_reg;
    assign sync_state       = res_reg.sync_state;
    assign keyboard_state   = res_reg.keyboard_state;
    assign clipboard_state  = res_reg.clipboard_state;
    assign sync_usable      = res_reg.sync_usable;
    assign keyboard_usable  = res_reg.keyboard_usable;
    assign clipboard_usable = res_reg.clipboard_usable;
    assign probe_running    = res_reg.probe_running;

`ifndef SYNTH
    // Input is held back only while a word waits in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> in_valid_reg)
    else $error("stall raised with an empty input register");
`endif

endmodule

// ----- sv/tcrp_parser.sv -----
module tcrp_parser
    import tcrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] reply_byte,
    input  logic       reply_last,
    output reply_t     reply
);

    phase_t               phase_reg, phase_next;
    logic                 priv_reg, priv_next;
    logic [PARAM_W-1:0]   acc_reg, acc_next;
    logic                 seen_reg, seen_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic [PARAM_W-1:0]   first_reg, first_next;
    logic [PARAM_W-1:0]   second_reg, second_next;
    logic                 ext52_reg, ext52_next;
    logic [7:0]           inter_reg, inter_next;
    logic [7:0]           fin_reg, fin_next;

    logic                 do_param;
    logic                 push_en;
    logic [PARAM_W-1:0]   push_v;
    logic                 done;

    always_comb
    begin
        phase_next  = phase_reg;
        priv_next   = priv_reg;
        acc_next    = acc_reg;
        seen_next   = seen_reg;
        cnt_next    = cnt_reg;
        first_next  = first_reg;
        second_next = second_reg;
        ext52_next  = ext52_reg;
        inter_next  = inter_reg;
        fin_next    = fin_reg;
        do_param    = 1'b0;
        push_en     = 1'b0;
        push_v      = acc_reg;

        case (phase_reg)
            PH_ESC:
            begin
                phase_next = (reply_byte == CH_ESC) ? PH_BRACKET : PH_BAD;
            end
            PH_BRACKET:
            begin
                phase_next = (reply_byte == CH_BRACKET) ? PH_FIRST : PH_BAD;
            end
            PH_FIRST:
            begin
                phase_next = PH_PARAMS;
                if (reply_byte == CH_QMARK)
                begin
                    priv_next = 1'b1;
                end
                else
                begin
                    do_param = 1'b1;
                end
            end
            PH_PARAMS:
            begin
                do_param = 1'b1;
            end
            PH_FINAL:
            begin
                fin_next   = reply_byte;
                phase_next = PH_DONE;
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_BAD;
            end
        endcase

        if (do_param)
        begin
            if (reply_byte inside {[8'h30:8'h39]})
            begin
                if (acc_reg < DIGIT_LIMIT)
                begin
                    acc_next = {acc_reg[PARAM_W-4:0], 3'b000} + {acc_reg[PARAM_W-2:0], 1'b0}
                               + {{(PARAM_W-4){1'b0}}, reply_byte[3:0]};
                end
                seen_next = 1'b1;
            end
            else if (reply_byte == CH_SEMI)
            begin
                push_en   = 1'b1;
                push_v    = seen_reg ? acc_reg : '0;
                acc_next  = '0;
                seen_next = 1'b0;
            end
            else
            begin
                push_en   = seen_reg;
                acc_next  = '0;
                seen_next = 1'b0;
                if (reply_byte inside {[8'h20:8'h2f]})
                begin
                    inter_next = reply_byte;
                    phase_next = PH_FINAL;
                end
                else
                begin
                    fin_next   = reply_byte;
                    phase_next = PH_DONE;
                end
            end
        end

        if (push_en)
        begin
            if (cnt_reg == 2'd0)
            begin
                first_next = push_v;
            end
            else if (cnt_reg == 2'd1)
            begin
                second_next = push_v;
            end
            if (cnt_reg != 2'd0 && push_v == PARAM_EXT52)
            begin
                ext52_next = 1'b1;
            end
            if (cnt_reg < 2'd2)
            begin
                cnt_next = cnt_reg + 2'd1;
            end
        end
    end

    assign done = reply_last && (phase_next == PH_DONE) && priv_next;

    always_comb
    begin
        reply.clip         = done && (fin_next == CH_LOW_C);
        reply.clip_present = ext52_next;
        reply.sync         = done && (fin_next == CH_LOW_Y) && (inter_next == CH_DOLLAR)
                             && (cnt_next >= 2'd2) && (first_next == PARAM_SYNC);
        reply.sync_present = (second_next >= 24'd1) && (second_next <= 24'd3);
        reply.kbd          = done && (fin_next == CH_LOW_U);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ESC;
            priv_reg   <= 1'b0;
            acc_reg    <= '0;
            seen_reg   <= 1'b0;
            cnt_reg    <= 2'd0;
            first_reg  <= '0;
            second_reg <= '0;
            ext52_reg  <= 1'b0;
            inter_reg  <= '0;
            fin_reg    <= '0;
        end
        else if (step)
        begin
            if (reply_last)
            begin
                phase_reg  <= PH_ESC;
                priv_reg   <= 1'b0;
                acc_reg    <= '0;
                seen_reg   <= 1'b0;
                cnt_reg    <= 2'd0;
                first_reg  <= '0;
                second_reg <= '0;
                ext52_reg  <= 1'b0;
                inter_reg  <= '0;
                fin_reg    <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                priv_reg   <= priv_next;
                acc_reg    <= acc_next;
                seen_reg   <= seen_next;
                cnt_reg    <= cnt_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                ext52_reg  <= ext52_next;
                inter_reg  <= inter_next;
                fin_reg    <= fin_next;
            end
        end
    end

`ifndef SYNTH
    // A completed reply always leaves the parser back at the start, fully cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && reply_last) |=> (phase_reg == PH_ESC && acc_reg == '0 && cnt_reg == 2'd0))
    else $error("parser not cleared after last byte");

    // The accumulator never grows past the value reachable from just below the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg <= 24'd9999999)
    else $error("digit accumulator out of range");
`endif

endmodule

// ----- sv/tcrp_answers.sv -----
module tcrp_answers
    import tcrp_pkg::*;
#(
    parameter int TICK_WIDTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  op_t                 operation,
    input  reply_t              reply,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [WINDOW_W-1:0] cfg_data,
    output result_t             result_next
);

    localparam int CW = (TICK_WIDTH + 1 > WINDOW_W) ? TICK_WIDTH + 1 : WINDOW_W;

    logic [WINDOW_W-1:0]   window_reg;
    logic [1:0]            ovr_sync_reg;
    logic [1:0]            ovr_kbd_reg;
    logic [1:0]            ovr_clip_reg;

    logic [1:0]            sync_reg, sync_next;
    logic [1:0]            kbd_reg, kbd_next;
    logic [1:0]            clip_reg, clip_next;
    logic                  active_reg, active_next;
    logic [TICK_WIDTH-1:0] ticks_reg, ticks_next;

    logic [TICK_WIDTH:0]   tick_inc;

    function automatic logic usable(input logic [1:0] ovr, input logic [1:0] ans);
        logic u;
        if (ovr == OVR_FORCE_ON)
        begin
            u = 1'b1;
        end
        else if (ovr == OVR_FORCE_OFF)
        begin
            u = 1'b0;
        end
        else
        begin
            u = (ans == ANS_PRESENT);
        end
        return u;
    endfunction

    assign tick_inc = {1'b0, ticks_reg} + {{TICK_WIDTH{1'b0}}, 1'b1};

    always_comb
    begin
        sync_next   = sync_reg;
        kbd_next    = kbd_reg;
        clip_next   = clip_reg;
        active_next = active_reg;
        ticks_next  = ticks_reg;

        case (operation)
            OP_BYTE:
            begin
                if (active_reg)
                begin
                    if (reply.clip)
                    begin
                        clip_next   = reply.clip_present ? ANS_PRESENT : ANS_ABSENT;
                        active_next = 1'b0;
                    end
                    else if (reply.sync)
                    begin
                        sync_next = reply.sync_present ? ANS_PRESENT : ANS_ABSENT;
                    end
                    else if (reply.kbd)
                    begin
                        kbd_next = ANS_PRESENT;
                    end
                end
            end
            OP_PROBE:
            begin
                sync_next   = ANS_UNKNOWN;
                kbd_next    = ANS_UNKNOWN;
                clip_next   = ANS_UNKNOWN;
                ticks_next  = '0;
                active_next = 1'b1;
            end
            OP_TICK:
            begin
                if (active_reg)
                begin
                    if (CW'(tick_inc) > CW'(window_reg))
                    begin
                        active_next = 1'b0;
                    end
                    ticks_next = tick_inc[TICK_WIDTH] ? {TICK_WIDTH{1'b1}}
                                                      : tick_inc[TICK_WIDTH-1:0];
                end
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase
    end

    always_comb
    begin
        result_next.sync_state       = sync_next;
        result_next.keyboard_state   = kbd_next;
        result_next.clipboard_state  = clip_next;
        result_next.sync_usable      = usable(ovr_sync_reg, sync_next);
        result_next.keyboard_usable  = usable(ovr_kbd_reg, kbd_next);
        result_next.clipboard_usable = usable(ovr_clip_reg, clip_next);
        result_next.probe_running    = active_next && (CW'(ticks_next) <= CW'(window_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg   <= ANS_UNKNOWN;
            kbd_reg    <= ANS_UNKNOWN;
            clip_reg   <= ANS_UNKNOWN;
            active_reg <= 1'b0;
            ticks_reg  <= '0;
        end
        else if (step)
        begin
            sync_reg   <= sync_next;
            kbd_reg    <= kbd_next;
            clip_reg   <= clip_next;
            active_reg <= active_next;
            ticks_reg  <= ticks_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= WINDOW_W'(100);
            ovr_sync_reg <= 2'd0;
            ovr_kbd_reg  <= 2'd0;
            ovr_clip_reg <= 2'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW:   window_reg   <= cfg_data;
                CFG_OVR_SYNC: ovr_sync_reg <= cfg_data[1:0];
                CFG_OVR_KBD:  ovr_kbd_reg  <= cfg_data[1:0];
                CFG_OVR_CLIP: ovr_clip_reg <= cfg_data[1:0];
                default:      window_reg   <= window_reg;
            endcase
        end
    end

`ifndef SYNTH
    // Replies received outside a probe must leave every answer alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && operation == OP_BYTE && !active_reg)
        |=> ($stable(sync_reg) && $stable(kbd_reg) && $stable(clip_reg)))
    else $error("answer changed outside a probe");

    // The tick count only moves while probing or when a probe starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!active_reg && !(step && operation == OP_PROBE)) |=> $stable(ticks_reg))
    else $error("tick count moved while idle");
`endif

endmodule
